### hw/rtl/chd_pkg.sv
package chd_pkg;

   // Fixed field widths
   localparam int CAP_W    = 24;
   localparam int BYTE_W   = 8;
   localparam int LINE_W   = 6;
   localparam logic [LINE_W-1:0] LINE_SAT = 6'd63;

   // Defaults for the top-level parameters
   localparam int SIZE_LINE_MAX_DEF   = 32;
   localparam int CHUNK_SIZE_BITS_DEF = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 24'hFF_FFFF;

   localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2B;

   typedef enum logic [2:0] {
      PH_LINE   = 3'd0,
      PH_DATA   = 3'd1,
      PH_TRAIL1 = 3'd2,
      PH_TRAIL2 = 3'd3,
      PH_HALT   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      DG_SKIP   = 2'd0,
      DG_DIGITS = 2'd1,
      DG_STOP   = 2'd2
   } digit_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_byte_valid;
      logic              done_res;
      logic              status;
      logic [CAP_W-1:0]  decoded_length;
   } rsp_type;

   // Result of the parser for one beat
   typedef struct packed {
      logic    present;
      rsp_type payload;
   } result_type;

   // {valid, value} of an ASCII hex digit
   function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // Space, TAB, LF, VT, FF, CR
   function automatic logic is_space(input logic [BYTE_W-1:0] b);
      return (b inside {8'h20, [8'h09:8'h0D]});
   endfunction

endpackage

### hw/rtl/http_chunked_decoder_unit.sv
// Beats pass the input register, the parser and the result register; those with no result
// leave nothing on rsp_. Throughput: one beat per cycle unless rsp_stall holds a result.
// req_stall rises only while the input register and the result register are
// both full and rsp_stall is high.
// Reset (synchronous, active high): parser returns to the size line start,
// both stages empty, capacity register back to its full 24-bit value.
module http_chunked_decoder_unit
   import chd_pkg::*;
#(
   parameter int SIZE_LINE_MAX   = SIZE_LINE_MAX_DEF,
   parameter int CHUNK_SIZE_BITS = CHUNK_SIZE_BITS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_write_enable,
   input  logic [CAP_W-1:0] csr_write_data
);

   logic [CAP_W-1:0] cap_ff;
   logic             advance;
   logic             step;
   req_type          item;
   result_type       result;

   // Output buffer capacity; the user must write it only while idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   // Input register: hold the beat until the result side can take its outcome.
   chd_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .advance     (advance),
      .step        (step),
      .item        (item)
   );

   // Parser: size line, data, trailer and commit, all in one pass per beat.
   chd_parser #(
      .SIZE_LINE_MAX   (SIZE_LINE_MAX),
      .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (item),
      .capacity (cap_ff),
      .result   (result)
   );

   // Result register: drop beats that give no result, hold one under stall.
   chd_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_cfg_when_idle : assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |-> !req_valid && !rsp_valid)
      else $error("capacity written while beats in flight");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side free");

   a_result_needs_step : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step))
      else $error("result appeared without a processed beat");

endmodule

### hw/rtl/chd_in_stage.sv
module chd_in_stage
   import chd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    advance,
   output logic    step,
   output req_type item
);

   logic    valid_ff;
   req_type item_ff;

   assign req_stall = valid_ff && !advance;
   assign step      = valid_ff && advance;
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_payload;
      end
   end

endmodule

### hw/rtl/chd_parser.sv
module chd_parser
   import chd_pkg::*;
#(
   parameter int SIZE_LINE_MAX   = SIZE_LINE_MAX_DEF,
   parameter int CHUNK_SIZE_BITS = CHUNK_SIZE_BITS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  req_type          item,
   input  logic [CAP_W-1:0] capacity,
   output result_type       result
);

   localparam int CW = (CHUNK_SIZE_BITS > CAP_W) ? CHUNK_SIZE_BITS : CAP_W;

   phase_type                  phase_ff, phase_in;
   digit_type                  digit_ff, digit_in;
   logic [LINE_W-1:0]          line_ff, line_in;
   logic                       cr_ff, cr_in;
   logic [CHUNK_SIZE_BITS-1:0] chunk_ff, chunk_in;
   logic [CHUNK_SIZE_BITS-1:0] remain_ff, remain_in;
   logic [CAP_W-1:0]           committed_ff, committed_in;
   logic                       error_ff, error_in;

   logic [4:0]       hexv;
   logic             take_digit;
   logic             emit;
   logic [LINE_W:0]  line_sum;
   logic [1:0]       line_inc;
   logic [CAP_W-1:0] room;
   logic [CW-1:0]    total;

   assign hexv  = hex_decode(item.in_byte);
   assign room  = capacity - committed_ff;
   assign total = CW'(committed_ff) + CW'(chunk_ff);

   always_comb begin
      phase_in     = phase_ff;
      digit_in     = digit_ff;
      line_in      = line_ff;
      cr_in        = cr_ff;
      chunk_in     = chunk_ff;
      remain_in    = remain_ff;
      committed_in = committed_ff;
      error_in     = error_ff;
      emit         = 1'b0;
      take_digit   = 1'b0;
      line_inc     = 2'd0;
      line_sum     = '0;

      case (phase_ff)
         PH_LINE: begin
            if (cr_ff && item.in_byte == CHAR_LF) begin
               // end of size line
               cr_in = 1'b0;
               if (line_ff >= LINE_W'(SIZE_LINE_MAX)) begin
                  error_in = 1'b1;
                  phase_in = PH_HALT;
               end else if (chunk_ff == '0) begin
                  phase_in = PH_HALT;
               end else begin
                  remain_in = chunk_ff;
                  phase_in  = PH_DATA;
               end
               line_in  = '0;
               digit_in = DG_SKIP;
            end else begin
               // count a pending bare CR, and this byte unless it is a CR
               line_inc = 2'(cr_ff) + 2'(item.in_byte != CHAR_CR);
               line_sum = {1'b0, line_ff} + (LINE_W + 1)'(line_inc);
               line_in  = (line_sum > {1'b0, LINE_SAT}) ? LINE_SAT : line_sum[LINE_W-1:0];
               cr_in    = (item.in_byte == CHAR_CR);
               case (digit_ff)
                  DG_SKIP: begin
                     if (is_space(item.in_byte)) begin
                        digit_in = DG_SKIP;
                     end else if (item.in_byte == CHAR_PLUS) begin
                        digit_in = DG_DIGITS;
                     end else begin
                        take_digit = 1'b1;
                     end
                  end
                  DG_DIGITS: take_digit = 1'b1;
                  default:   digit_in = DG_STOP;
               endcase
               if (take_digit) begin
                  if (!hexv[4]) begin
                     digit_in = DG_STOP;
                  end else begin
                     digit_in = DG_DIGITS;
                     // saturate once the top nibble is in use
                     if (chunk_ff[CHUNK_SIZE_BITS-1 -: 4] != 4'd0) begin
                        chunk_in = '1;
                     end else begin
                        chunk_in = {chunk_ff[CHUNK_SIZE_BITS-5:0], hexv[3:0]};
                     end
                  end
               end
            end
         end
         PH_DATA: begin
            emit = 1'b1;
            if (remain_ff <= CHUNK_SIZE_BITS'(1)) begin
               remain_in = '0;
               phase_in  = PH_TRAIL1;
            end else begin
               remain_in = remain_ff - CHUNK_SIZE_BITS'(1);
            end
         end
         PH_TRAIL1: phase_in = PH_TRAIL2;
         PH_TRAIL2: begin
            // commit the chunk if it fits in the capacity, else flag an error
            if (committed_ff > capacity || CW'(chunk_ff) > CW'(room)) begin
               error_in = 1'b1;
               phase_in = PH_HALT;
            end else begin
               committed_in = total[CAP_W-1:0];
               chunk_in     = '0;
               remain_in    = '0;
               phase_in     = PH_LINE;
            end
         end
         default: phase_in = phase_ff;
      endcase

      result.present                = emit || item.in_last;
      result.payload.out_byte       = emit ? item.in_byte : '0;
      result.payload.out_byte_valid = emit;
      result.payload.done_res       = item.in_last;
      result.payload.status         = item.in_last && error_in;
      result.payload.decoded_length = (item.in_last && !error_in) ? committed_in : '0;

      if (item.in_last) begin
         phase_in     = PH_LINE;
         digit_in     = DG_SKIP;
         line_in      = '0;
         cr_in        = 1'b0;
         chunk_in     = '0;
         remain_in    = '0;
         committed_in = '0;
         error_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINE;
         digit_ff     <= DG_SKIP;
         line_ff      <= '0;
         cr_ff        <= 1'b0;
         chunk_ff     <= '0;
         remain_ff    <= '0;
         committed_ff <= '0;
         error_ff     <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         digit_ff     <= digit_in;
         line_ff      <= line_in;
         cr_ff        <= cr_in;
         chunk_ff     <= chunk_in;
         remain_ff    <= remain_in;
         committed_ff <= committed_in;
         error_ff     <= error_in;
      end
   end

   a_data_has_remaining : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remain_ff != '0)
      else $error("data phase with nothing remaining");

   a_error_halts : assert property (@(posedge clock) disable iff (reset)
      error_ff |-> phase_ff == PH_HALT)
      else $error("error flag set outside halt");

   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      step && item.in_last |=> phase_ff == PH_LINE && committed_ff == '0 && !error_ff)
      else $error("state not cleared after last beat");

endmodule

### hw/rtl/chd_out_stage.sv
module chd_out_stage
   import chd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  result_type result,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload
);

   logic    valid_ff;
   rsp_type payload_ff;

   assign advance     = !valid_ff || !rsp_stall;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= step && result.present;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         payload_ff <= result.payload;
      end
   end

endmodule
